// ===== rtl/rjd_pkg.sv =====
// Shared types, constants and helper functions for the rod Jacobian derivative block.
// Depends on nothing; used by rjd_lane and rod_jacobian_derivative.
package rjd_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int WORD_W        = 32;
    localparam int WIDE_W        = 68;
    localparam int NUM_LANES     = 6;
    localparam int S_TDATA_W     = 200;
    localparam int M_TDATA_W     = 200;
    localparam int COL_W         = 3;

    localparam logic [1:0] OP_COSTATE = 2'd0;
    localparam logic [1:0] OP_MCOL    = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [2:0] CFG_MODEL  = 3'd6;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [NUM_LANES-1:0]    vec6_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_UMUL,
        ST_USAT,
        ST_EF,
        ST_MF,
        ST_MG,
        ST_MH
    } step_t;

    typedef struct packed {
        step_t      step;
        logic [2:0] j;
        logic       start;
    } lane_ctl_t;

    typedef enum logic [1:0] { EK_ZERO, EK_PROD, EK_U } ent_kind_t;
    typedef enum logic [1:0] { C_NONE, C_PONE, C_MONE } ent_cst_t;

    typedef struct packed {
        ent_kind_t  kind;
        logic       neg;
        ent_cst_t   cst;
        logic [2:0] mu_idx;
        logic       use_b;
        logic [2:0] idx;
    } ent_t;

    function automatic word_t sat32(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = WIDE_W'(32'sh7fffffff);
        lo = -WIDE_W'(33'sh080000000);
        if (v > hi) return word_t'(32'h7fffffff);
        if (v < lo) return word_t'(32'h80000000);
        return word_t'(v[WORD_W-1:0]);
    endfunction

    function automatic ent_t mk_p(input logic neg, input logic [2:0] mu,
                                  input logic use_b, input logic [2:0] idx,
                                  input ent_cst_t cst);
        ent_t e;
        e.kind = EK_PROD; e.neg = neg; e.cst = cst;
        e.mu_idx = mu; e.use_b = use_b; e.idx = idx;
        return e;
    endfunction

    function automatic ent_t mk_u(input logic neg, input logic [2:0] idx,
                                  input ent_cst_t cst);
        ent_t e;
        e.kind = EK_U; e.neg = neg; e.cst = cst;
        e.mu_idx = 3'd0; e.use_b = 1'b0; e.idx = idx;
        return e;
    endfunction

    function automatic ent_t mk_c(input ent_cst_t cst);
        ent_t e;
        e.kind = EK_ZERO; e.neg = 1'b0; e.cst = cst;
        e.mu_idx = 3'd0; e.use_b = 1'b0; e.idx = 3'd0;
        return e;
    endfunction

    // Describes entry (i, j) of F (is_h low) or H (is_h high).
    function automatic ent_t ent_desc(input logic is_h, input logic [2:0] i,
                                      input logic [2:0] j, input logic ext);
        ent_t e;
        e = mk_c(C_NONE);
        if (!is_h) begin
            unique case ({i, j})
                6'o01: e = mk_p(1'b0, 3'd2, 1'b1, 3'd0, C_NONE);
                6'o02: e = mk_p(1'b0, 3'd1, 1'b1, 3'd0, C_NONE);
                6'o04: if (ext) e = mk_p(1'b0, 3'd5, 1'b1, 3'd3, C_NONE);
                6'o05: if (ext) e = mk_p(1'b0, 3'd4, 1'b1, 3'd3, C_NONE);
                6'o10: e = mk_p(1'b0, 3'd2, 1'b1, 3'd1, C_NONE);
                6'o12: e = mk_p(1'b0, 3'd0, 1'b1, 3'd1, C_NONE);
                6'o13: if (ext) e = mk_p(1'b0, 3'd5, 1'b1, 3'd4, C_NONE);
                6'o15: begin
                    if (ext) e = mk_p(1'b0, 3'd3, 1'b1, 3'd4, C_PONE);
                    else     e = mk_c(C_PONE);
                end
                6'o20: e = mk_p(1'b0, 3'd1, 1'b1, 3'd2, C_NONE);
                6'o21: e = mk_p(1'b0, 3'd0, 1'b1, 3'd2, C_NONE);
                6'o23: if (ext) e = mk_p(1'b0, 3'd4, 1'b1, 3'd5, C_NONE);
                6'o24: begin
                    if (ext) e = mk_p(1'b0, 3'd3, 1'b1, 3'd5, C_MONE);
                    else     e = mk_c(C_MONE);
                end
                6'o31: e = mk_p(1'b1, 3'd5, 1'b0, 3'd1, C_NONE);
                6'o32: e = mk_p(1'b0, 3'd4, 1'b0, 3'd2, C_NONE);
                6'o34: e = mk_u(1'b0, 3'd2, C_NONE);
                6'o35: e = mk_u(1'b1, 3'd1, C_NONE);
                6'o40: e = mk_p(1'b0, 3'd5, 1'b0, 3'd0, C_NONE);
                6'o42: e = mk_p(1'b1, 3'd3, 1'b0, 3'd2, C_NONE);
                6'o43: e = mk_u(1'b1, 3'd2, C_NONE);
                6'o45: e = mk_u(1'b0, 3'd0, C_NONE);
                6'o50: e = mk_p(1'b1, 3'd4, 1'b0, 3'd0, C_NONE);
                6'o51: e = mk_p(1'b0, 3'd3, 1'b0, 3'd1, C_NONE);
                6'o53: e = mk_u(1'b0, 3'd1, C_NONE);
                6'o54: e = mk_u(1'b1, 3'd0, C_NONE);
                default: e = mk_c(C_NONE);
            endcase
        end else begin
            unique case ({i, j})
                6'o01: e = mk_u(1'b0, 3'd2, C_NONE);
                6'o02: e = mk_u(1'b1, 3'd1, C_NONE);
                6'o10: e = mk_u(1'b1, 3'd2, C_NONE);
                6'o12: e = mk_u(1'b0, 3'd0, C_NONE);
                6'o20: e = mk_u(1'b0, 3'd1, C_NONE);
                6'o21: e = mk_u(1'b1, 3'd0, C_NONE);
                6'o31: if (ext) e = mk_u(1'b0, 3'd5, C_NONE);
                6'o32: if (ext) e = mk_u(1'b1, 3'd4, C_NONE);
                6'o34: e = mk_u(1'b0, 3'd2, C_NONE);
                6'o35: e = mk_u(1'b1, 3'd1, C_NONE);
                6'o40: if (ext) e = mk_u(1'b1, 3'd5, C_NONE);
                6'o42: begin
                    if (ext) e = mk_u(1'b0, 3'd3, C_PONE);
                    else     e = mk_c(C_PONE);
                end
                6'o43: e = mk_u(1'b1, 3'd2, C_NONE);
                6'o45: e = mk_u(1'b0, 3'd0, C_NONE);
                6'o50: if (ext) e = mk_u(1'b0, 3'd4, C_NONE);
                6'o51: begin
                    if (ext) e = mk_u(1'b1, 3'd3, C_MONE);
                    else     e = mk_c(C_MONE);
                end
                6'o53: e = mk_u(1'b0, 3'd1, C_NONE);
                6'o54: e = mk_u(1'b1, 3'd0, C_NONE);
                default: e = mk_c(C_NONE);
            endcase
        end
        return e;
    endfunction

endpackage

// ===== rtl/rjd_lane.sv =====
// One row lane: a shared 32x32 multiplier that forms the costate-compliance product,
// the row's matrix entries and the dM and dJ dot products. Depends on rjd_pkg.
module rjd_lane import rjd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int LANE      = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  lane_ctl_t ctl,
    input  logic      ext,
    input  vec6_t     mu,
    input  vec6_t     comp,
    input  vec6_t     bdiff,
    input  vec6_t     m_col,
    input  vec6_t     j_col,
    input  vec6_t     u_all,
    output word_t     u_val,
    output word_t     dm,
    output word_t     dj
);

    localparam logic [2:0] ROW = 3'(LANE);

    logic signed [63:0] prod_reg, prod_next;
    step_t              tag_reg;
    wide_t              acc_m_reg, acc_j_reg;
    word_t              u_reg;
    wide_t              prod_sh, one_w, base, term;
    ent_t               desc;
    word_t              mul_a, mul_b, ent_val, g_val;

    assign one_w   = wide_t'(1) <<< FRAC_BITS;
    assign prod_sh = wide_t'(prod_reg >>> FRAC_BITS);

    always_comb begin
        desc = ent_desc(ctl.step == ST_MH, ROW, ctl.j, ext);
        unique case (desc.kind)
            EK_PROD: base = prod_sh;
            EK_U:    base = wide_t'(u_all[desc.idx]);
            default: base = '0;
        endcase
        term = desc.neg ? -base : base;
        unique case (desc.cst)
            C_PONE:  term = term + one_w;
            C_MONE:  term = term - one_w;
            default: term = term;
        endcase
        ent_val = sat32(term);
        g_val   = (ctl.j == ROW && (ext || LANE < 3)) ? comp[LANE] : '0;

        unique case (ctl.step)
            ST_UMUL: begin mul_a = mu[LANE];          mul_b = comp[LANE]; end
            ST_EF: begin
                mul_a = mu[desc.mu_idx];
                mul_b = desc.use_b ? bdiff[desc.idx] : comp[desc.idx];
            end
            ST_MF:   begin mul_a = ent_val; mul_b = m_col[ctl.j]; end
            ST_MG:   begin mul_a = g_val;   mul_b = m_col[ctl.j]; end
            ST_MH:   begin mul_a = ent_val; mul_b = j_col[ctl.j]; end
            default: begin mul_a = '0;      mul_b = '0;           end
        endcase
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) begin
            tag_reg <= ST_NONE;
        end else begin
            tag_reg <= ctl.step;
        end
        if (ctl.step == ST_USAT) begin
            u_reg <= sat32(prod_sh);
        end
        if (ctl.start) begin
            acc_m_reg <= '0;
            acc_j_reg <= '0;
        end else if (tag_reg == ST_MF) begin
            acc_m_reg <= acc_m_reg + prod_sh;
        end else if (tag_reg == ST_MG || tag_reg == ST_MH) begin
            acc_j_reg <= acc_j_reg + prod_sh;
        end
    end

    assign u_val = u_reg;
    assign dm    = sat32(acc_m_reg);
    assign dj    = sat32(acc_j_reg);

endmodule

// ===== rtl/rod_jacobian_derivative.sv =====
// Top level of the rod Jacobian derivative block: stream ports, configuration
// registers, sequencer, six row lanes and the output merge. Depends on rjd_pkg, rjd_lane.
//
// The block computes one column of dM = F*M and of dJ = G*M + H*J per compute
// transaction. A transaction with s_tuser = 0 loads the costate, one with
// s_tuser = 1 loads a column of M; both give no result. A transaction with
// s_tuser = 2 carries the matching column of J and starts the computation: six
// row lanes, each with one 32x32 multiplier, run in step. The lanes first form
// the costate-compliance products, then saturate them, and then each of the six
// columns takes four multiplier passes (matrix entry, F*M, G*M, H*J). The dM
// column follows as one output transaction and the dJ column, marked by m_tlast,
// as the next; a new input transaction is taken once the dJ transaction has gone,
// so output stalls hold off further input. Reserved codes in s_tuser are accepted
// and dropped. Configuration writes are taken on every cycle and must only be
// issued while the block is idle; index 6 sets the rod model, and indices 0 to 5
// set the compliances.
module rod_jacobian_derivative import rjd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // column[2:0], value_0..value_5 (32 bits each), zero pad
    input  logic [1:0]           s_tuser,  // op
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_column[2:0], result_0..result_5, zero pad
    output logic                 m_tuser,  // which
    output logic                 m_tlast,  // last
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_UMUL, S_USAT, S_RUN, S_DRAIN, S_FIN, S_OUT_M, S_OUT_J
    } state_t;

    localparam int RESULT_DELAY = 29;

    state_t     state_reg;
    logic [2:0] j_reg;
    logic [1:0] k_reg;
    vec6_t      comp_reg, mu_reg, m_reg, v_reg, b_reg, dm_reg, dj_reg;
    logic       model_reg;
    logic [2:0] col_reg;
    vec6_t      s_vals, b_next, u_all, dm_w, dj_w, res;
    lane_ctl_t  ctl;
    logic       s_acc, m_acc, cfg_acc;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            s_vals[i] = word_t'(s_tdata[COL_W + WORD_W*i +: WORD_W]);
        end
        b_next[0] = sat32(wide_t'(comp_reg[2]) - wide_t'(comp_reg[1]));
        b_next[1] = sat32(wide_t'(comp_reg[0]) - wide_t'(comp_reg[2]));
        b_next[2] = sat32(wide_t'(comp_reg[1]) - wide_t'(comp_reg[0]));
        b_next[3] = sat32(wide_t'(comp_reg[5]) - wide_t'(comp_reg[4]));
        b_next[4] = sat32(wide_t'(comp_reg[3]) - wide_t'(comp_reg[5]));
        b_next[5] = sat32(wide_t'(comp_reg[4]) - wide_t'(comp_reg[3]));
    end

    // Lane control follows the sequencer state; in the run phase k picks the pass.
    always_comb begin
        ctl.j     = j_reg;
        ctl.start = s_acc && (s_tuser == OP_COMPUTE);
        unique case (state_reg)
            S_UMUL: ctl.step = ST_UMUL;
            S_USAT: ctl.step = ST_USAT;
            S_RUN: begin
                unique case (k_reg)
                    2'd0:    ctl.step = ST_EF;
                    2'd1:    ctl.step = ST_MF;
                    2'd2:    ctl.step = ST_MG;
                    default: ctl.step = ST_MH;
                endcase
            end
            default: ctl.step = ST_NONE;
        endcase
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rjd_lane #(
            .FRAC_BITS(FRAC_BITS),
            .LANE     (g)
        ) u_lane (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctl    (ctl),
            .ext    (model_reg),
            .mu     (mu_reg),
            .comp   (comp_reg),
            .bdiff  (b_reg),
            .m_col  (m_reg),
            .j_col  (v_reg),
            .u_all  (u_all),
            .u_val  (u_all[g]),
            .dm     (dm_w[g]),
            .dj     (dj_w[g])
        );
    end

    // Sequencer, loaded operands and the merged output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
            comp_reg  <= '0;
            model_reg <= 1'b0;
            mu_reg    <= '0;
            m_reg     <= '0;
        end else begin
            if (cfg_acc) begin
                if (cfg_index < CFG_MODEL) begin
                    comp_reg[cfg_index] <= word_t'(cfg_data);
                end else if (cfg_index == CFG_MODEL) begin
                    model_reg <= cfg_data[0];
                end
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        // A reserved code is taken and changes nothing.
                        unique case (s_tuser)
                            OP_COSTATE: mu_reg <= s_vals;
                            OP_MCOL:    m_reg  <= s_vals;
                            OP_COMPUTE: begin
                                v_reg     <= s_vals;
                                b_reg     <= b_next;
                                col_reg   <= s_tdata[COL_W-1:0];
                                state_reg <= S_UMUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_UMUL: state_reg <= S_USAT;
                S_USAT: begin
                    j_reg     <= '0;
                    k_reg     <= '0;
                    state_reg <= S_RUN;
                end
                S_RUN: begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        if (j_reg == 3'(NUM_LANES - 1)) begin
                            state_reg <= S_DRAIN;
                        end else begin
                            j_reg <= j_reg + 3'd1;
                        end
                    end
                end
                S_DRAIN: state_reg <= S_FIN;
                S_FIN: begin
                    dm_reg    <= dm_w;
                    dj_reg    <= dj_w;
                    state_reg <= S_OUT_M;
                end
                S_OUT_M: if (m_acc) state_reg <= S_OUT_J;
                S_OUT_J: if (m_acc) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = (state_reg == S_OUT_M) || (state_reg == S_OUT_J);
    assign m_tuser  = (state_reg == S_OUT_J);
    assign m_tlast  = (state_reg == S_OUT_J);
    assign res      = (state_reg == S_OUT_J) ? dj_reg : dm_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[COL_W-1:0] = col_reg;
        for (int i = 0; i < NUM_LANES; i++) begin
            m_tdata[COL_W + WORD_W*i +: WORD_W] = res[i];
        end
    end

    // The input side and the output side are never open at once.
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input accepted while a result is pending");

    // The dM transaction is always followed directly by the dJ transaction.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("dJ column did not follow the dM column");

    // A compute transaction yields its dM column after a fixed latency.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_COMPUTE) |-> ##RESULT_DELAY
        (m_tvalid && !m_tlast))
        else $error("dM column not presented at the expected cycle");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for rod_jacobian_derivative. It drives the stream and
// configuration ports and checks every result against a built-in predictor.
// Depends on rjd_pkg and the rod_jacobian_derivative RTL.
`timescale 1ns / 1ps

// Keeps the predicted state and configuration, and the queue of derivative
// columns that are still to come out of the block.
class rod_derivative_board;
    typedef struct {
        bit       which;
        bit [2:0] col;
        int       rows[6];
        bit       last;
    } column_t;

    int      compliance[6];
    bit      extensible;
    int      costate[6];
    int      m_column[6];
    column_t pending_columns[$];
    int      errors;

    function new();
        errors = 0;
        extensible = 0;
        foreach (compliance[i]) compliance[i] = 0;
        foreach (costate[i]) costate[i] = 0;
        foreach (m_column[i]) m_column[i] = 0;
    endfunction

    function automatic int sat(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    // Full-width product, low fraction bits dropped (rounds towards minus infinity).
    function automatic longint mulq(longint a, longint b);
        return (a * b) >>> rjd_pkg::FRAC_BITS_DEF;
    endfunction

    function automatic int entry(bit neg, int a, int b);
        longint p;
        p = mulq(a, b);
        return sat(neg ? -p : p);
    endfunction

    function void write_register(bit [2:0] index, bit [31:0] data);
        if (index == rjd_pkg::CFG_MODEL) extensible = data[0];
        else if (index < rjd_pkg::CFG_MODEL) compliance[index] = int'(data);
    endfunction

    // Records an accepted input transaction and predicts its results.
    function void note_input(bit [1:0] op, bit [2:0] col, int v[6]);
        longint one;
        int b[6], u[6];
        int f[6][6], g[6][6], h[6][6];
        longint sm, sj;
        column_t dm, dj;
        one = longint'(1) <<< rjd_pkg::FRAC_BITS_DEF;
        if (op == rjd_pkg::OP_COSTATE) begin
            costate = v;
            return;
        end
        if (op == rjd_pkg::OP_MCOL) begin
            m_column = v;
            return;
        end
        if (op != rjd_pkg::OP_COMPUTE) return;

        b[0] = sat(longint'(compliance[2]) - compliance[1]);
        b[1] = sat(longint'(compliance[0]) - compliance[2]);
        b[2] = sat(longint'(compliance[1]) - compliance[0]);
        b[3] = sat(longint'(compliance[5]) - compliance[4]);
        b[4] = sat(longint'(compliance[3]) - compliance[5]);
        b[5] = sat(longint'(compliance[4]) - compliance[3]);
        for (int i = 0; i < 6; i++) begin
            u[i] = sat(mulq(costate[i], compliance[i]));
            for (int j = 0; j < 6; j++) begin
                f[i][j] = 0;
                g[i][j] = 0;
                h[i][j] = 0;
            end
        end

        f[0][1] = entry(0, costate[2], b[0]);
        f[0][2] = entry(0, costate[1], b[0]);
        f[1][0] = entry(0, costate[2], b[1]);
        f[1][2] = entry(0, costate[0], b[1]);
        f[2][0] = entry(0, costate[1], b[2]);
        f[2][1] = entry(0, costate[0], b[2]);
        f[3][1] = entry(1, costate[5], compliance[1]);
        f[3][2] = entry(0, costate[4], compliance[2]);
        f[3][4] = u[2];
        f[3][5] = sat(-longint'(u[1]));
        f[4][0] = entry(0, costate[5], compliance[0]);
        f[4][2] = entry(1, costate[3], compliance[2]);
        f[4][3] = sat(-longint'(u[2]));
        f[4][5] = u[0];
        f[5][0] = entry(1, costate[4], compliance[0]);
        f[5][1] = entry(0, costate[3], compliance[1]);
        f[5][3] = u[1];
        f[5][4] = sat(-longint'(u[0]));
        if (extensible) begin
            f[0][4] = entry(0, costate[5], b[3]);
            f[0][5] = entry(0, costate[4], b[3]);
            f[1][3] = entry(0, costate[5], b[4]);
            f[1][5] = sat(one + mulq(costate[3], b[4]));
            f[2][3] = entry(0, costate[4], b[5]);
            f[2][4] = sat(-one + mulq(costate[3], b[5]));
        end else begin
            f[1][5] = sat(one);
            f[2][4] = sat(-one);
        end

        for (int i = 0; i < 6; i++) g[i][i] = (extensible || i < 3) ? compliance[i] : 0;

        h[0][1] = u[2];
        h[0][2] = sat(-longint'(u[1]));
        h[1][0] = sat(-longint'(u[2]));
        h[1][2] = u[0];
        h[2][0] = u[1];
        h[2][1] = sat(-longint'(u[0]));
        h[3][4] = u[2];
        h[3][5] = sat(-longint'(u[1]));
        h[4][3] = sat(-longint'(u[2]));
        h[4][5] = u[0];
        h[5][3] = u[1];
        h[5][4] = sat(-longint'(u[0]));
        if (extensible) begin
            h[3][1] = u[5];
            h[3][2] = sat(-longint'(u[4]));
            h[4][0] = sat(-longint'(u[5]));
            h[4][2] = sat(one + u[3]);
            h[5][0] = u[4];
            h[5][1] = sat(-one - u[3]);
        end else begin
            h[4][2] = sat(one);
            h[5][1] = sat(-one);
        end

        dm.which = 0; dm.col = col; dm.last = 0;
        dj.which = 1; dj.col = col; dj.last = 1;
        for (int i = 0; i < 6; i++) begin
            sm = 0;
            sj = 0;
            for (int j = 0; j < 6; j++) begin
                sm += mulq(f[i][j], m_column[j]);
                sj += mulq(g[i][j], m_column[j]);
                sj += mulq(h[i][j], v[j]);
            end
            dm.rows[i] = sat(sm);
            dj.rows[i] = sat(sj);
        end
        pending_columns.push_back(dm);
        pending_columns.push_back(dj);
    endfunction

    function void mismatch(string what, longint exp_v, longint act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        errors++;
    endfunction

    // Compares one accepted result transaction with the oldest prediction.
    function void check_result(bit which, bit [2:0] col, int rows[6], bit last);
        column_t e;
        if (pending_columns.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual column %0d", $time, col);
            errors++;
            return;
        end
        e = pending_columns.pop_front();
        if (which != e.which) mismatch("which", e.which, which);
        if (col != e.col) mismatch("out_column", e.col, col);
        if (last != e.last) mismatch("last", e.last, last);
        for (int i = 0; i < 6; i++)
            if (rows[i] != e.rows[i]) mismatch($sformatf("result_%0d", i), e.rows[i], rows[i]);
    endfunction
endclass

module tb;
    import rjd_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         HOLD_CYCLES    = 400;
    localparam bit [31:0]  ONE_Q          = 32'h0100_0000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    rod_derivative_board board;
    bit quiet_phase;   // no idling on either side
    bit hold_request;  // asks the receiver for one long hold-off
    int idle_cycles;

    rod_jacobian_derivative dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Picks operand values that reach saturation, the exact constants and ordinary magnitudes.
    function automatic bit [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 0;
            4: return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
            default: return $urandom_range(0, 32'h07ff_ffff) - 32'h0400_0000;
        endcase
    endfunction

    // Sends one input transaction; the caller is at a falling edge and returns at one.
    task automatic send_item(logic [1:0] op, logic [2:0] col, bit [31:0] v[6]);
        while (!quiet_phase && $urandom_range(0, 99) < 30) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = '0;
        s_tdata[2:0] = col;
        for (int i = 0; i < 6; i++) s_tdata[3 + 32*i +: 32] = v[i];
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random_values(logic [1:0] op, logic [2:0] col);
        bit [31:0] v[6];
        foreach (v[i]) v[i] = pick_word();
        send_item(op, col, v);
    endtask

    task automatic write_register(logic [2:0] index, bit [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Lets the block drain completely; loads give no result so a margin follows.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (board.pending_columns.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One random run: mostly well-formed costate, M, J triples, with some noise.
    task automatic random_traffic(int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                if ($urandom_range(0, 3) != 0) send_random_values(OP_COSTATE, 3'($urandom()));
                send_random_values(OP_MCOL, 3'($urandom()));
                send_random_values(OP_COMPUTE, 3'($urandom_range(0, 5)));
            end else if (kind < 85) begin
                send_random_values(OP_COMPUTE, 3'($urandom()));
            end else if (kind < 92) begin
                send_random_values(OP_RESERVED, 3'($urandom()));
            end else begin
                send_random_values(2'($urandom_range(0, 1)), 3'($urandom()));
            end
        end
    endtask

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready = quiet_phase || $urandom_range(0, 99) >= 30;
        end
    end

    // Monitors sample at the rising edge, before the block's own updates land.
    always @(posedge aclk) begin
        int v[6];
        int rows[6];
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                for (int i = 0; i < 6; i++) v[i] = s_tdata[3 + 32*i +: 32];
                board.note_input(s_tuser, s_tdata[2:0], v);
            end
            if (m_tvalid && m_tready) begin
                for (int i = 0; i < 6; i++) rows[i] = m_tdata[3 + 32*i +: 32];
                board.check_result(m_tuser, m_tdata[2:0], rows, m_tlast);
            end
            if (cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
        end
    end

    // Watchdog: ends the run if no transaction of any kind moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        bit [31:0] v[6];
        board = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_phase = 1'b0;
        hold_request = 1'b0;
        idle_cycles = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part, first with the registers at their reset values. A compute
        // with nothing loaded must use the zero costate and M column.
        foreach (v[i]) v[i] = 32'h7fff_ffff;
        send_item(OP_COMPUTE, 3'd0, v);
        send_item(OP_COMPUTE, 3'd7, v);
        wait_idle();

        write_register(3'd0, 32'h7fff_ffff);
        write_register(3'd1, 32'h8000_0000);
        write_register(3'd2, ONE_Q);
        write_register(3'd3, -ONE_Q);
        write_register(3'd4, 32'h7fff_ffff);
        write_register(3'd5, 32'h8000_0000);
        write_register(CFG_MODEL, 32'd1);
        write_register(CFG_UNUSED, 32'hffff_ffff);  // out of range, must be ignored

        // Extreme costate and columns, every op, and echoed column indexes 6 and 7.
        foreach (v[i]) v[i] = 32'h7fff_ffff;
        send_item(OP_COSTATE, 3'd5, v);
        foreach (v[i]) v[i] = 32'h8000_0000;
        send_item(OP_MCOL, 3'd6, v);
        send_item(OP_COMPUTE, 3'd6, v);
        send_item(OP_RESERVED, 3'd1, v);
        foreach (v[i]) v[i] = 32'h7fff_ffff;
        send_item(OP_COMPUTE, 3'd7, v);
        foreach (v[i]) v[i] = 32'h8000_0000;
        send_item(OP_COSTATE, 3'd0, v);
        foreach (v[i]) v[i] = ONE_Q;
        send_item(OP_MCOL, 3'd3, v);
        foreach (v[i]) v[i] = -ONE_Q;
        send_item(OP_COMPUTE, 3'd5, v);
        foreach (v[i]) v[i] = 0;
        send_item(OP_COSTATE, 3'd0, v);
        send_item(OP_COMPUTE, 3'd1, v);
        wait_idle();

        // Phases over several register settings; the model alternates between them.
        for (int phase = 0; phase < 5; phase++) begin
            for (int r = 0; r < 6; r++) begin
                case (phase)
                    0: write_register(3'(r), 0);
                    1: write_register(3'(r), $urandom_range(0, 32'h01ff_ffff));
                    2: write_register(3'(r), (r % 2) ? 32'h8000_0000 : 32'h7fff_ffff);
                    default: write_register(3'(r), pick_word());
                endcase
            end
            write_register(CFG_MODEL, phase % 2);
            quiet_phase = (phase == 3);
            if (phase == 1) hold_request = 1'b1;
            random_traffic(35);
            // In phase 2 the sender pauses here until every outstanding column has come back.
            if (phase == 2) begin
                s_tvalid = 1'b0;
                while (board.pending_columns.size() != 0) @(negedge aclk);
            end
            random_traffic(35);
            wait_idle();
        end
        quiet_phase = 1'b0;

        while (board.pending_columns.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== rod_jacobian_derivative.f =====
rtl/rjd_pkg.sv
rtl/rjd_lane.sv
rtl/rod_jacobian_derivative.sv
tb/tb.sv
